/* rtl/antq_pkg.sv */
// Package with the item types and codes of the node table query block.
`timescale 1ns / 1ps
package antq_pkg;

  localparam int unsigned CoordBits = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_HIT      = 3'd4,
    ST_NOHITS   = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  node_kind;
    logic [31:0] target_id;
    logic [5:0]  slot_index;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] node_id;
    logic [2:0]  kind_out;
    logic [31:0] node_generation;
    logic signed [31:0] out_min_x;
    logic signed [31:0] out_min_y;
    logic signed [31:0] out_min_z;
    logic signed [31:0] out_max_x;
    logic signed [31:0] out_max_y;
    logic signed [31:0] out_max_z;
    logic        last;
  } out_item_t;

  // Node record as held in the table: id, kind, generation, box.
  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  kind;
    logic [31:0] gen;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } node_t;

endpackage

/* rtl/antq_front.sv */
// Front stage: takes items, sign-extends coordinates and queues them.
`timescale 1ns / 1ps
module antq_front #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  antq_pkg::in_item_t in_item,
  output logic q_valid,
  input  logic q_pop,
  output antq_pkg::in_item_t q_item
);
  import antq_pkg::*;

  localparam int unsigned Cw = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  function automatic logic [31:0] sext(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int b = Cw; b < 32; b++) r[b] = v[Cw-1];
    return r;
  endfunction

  in_item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wr_r, rd_r;
  in_item_t norm;
  logic push;

  always_comb begin
    norm = in_item;
    norm.box_min_x = sext(in_item.box_min_x);
    norm.box_min_y = sext(in_item.box_min_y);
    norm.box_min_z = sext(in_item.box_min_z);
    norm.box_max_x = sext(in_item.box_max_x);
    norm.box_max_y = sext(in_item.box_max_y);
    norm.box_max_z = sext(in_item.box_max_z);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (q_pop && q_valid) rd_r <= !rd_r;
    end
    if (push) q_r[wr_r] <= norm;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an item");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> !q_valid)
    else $error("empty queue shows an item");
endmodule

/* rtl/antq_back.sv */
// Back stage: carries out table operations one item at a time, walking the table slot by slot.
`timescale 1ns / 1ps
module antq_back #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  antq_pkg::in_item_t q_item,
  output logic out_valid,
  input  logic out_stall,
  output antq_pkg::out_item_t out_item
);
  import antq_pkg::*;

  localparam int unsigned Iw = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned Nw = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_SHIFT, S_EMIT, S_OUT} state_t;

  node_t mem [CAPACITY];
  node_t rd_q;
  logic [Iw-1:0] rd_addr;

  state_t state_r;
  logic [Nw-1:0] cnt_r, idx_r;
  logic [31:0] next_id_r, world_gen_r;
  in_item_t cur_r;
  logic found_r;
  logic pend_r;
  out_item_t pend_item_r;
  out_item_t res_r;
  logic res_v_r;
  logic wr_en;
  logic [Iw-1:0] wr_addr;
  node_t wr_data;
  logic hit;

  function automatic out_item_t mk(input logic [2:0] st, input node_t n, input logic l);
    out_item_t o;
    o.status = st; o.node_id = n.id; o.kind_out = n.kind; o.node_generation = n.gen;
    o.out_min_x = n.min_x; o.out_min_y = n.min_y; o.out_min_z = n.min_z;
    o.out_max_x = n.max_x; o.out_max_y = n.max_y; o.out_max_z = n.max_z;
    o.last = l;
    return o;
  endfunction

  assign out_valid = res_v_r;
  assign out_item = res_r;
  wire out_free = !res_v_r || !out_stall;

  assign hit = (rd_q.min_x <= cur_r.box_max_x) && (cur_r.box_min_x <= rd_q.max_x) &&
               (rd_q.min_y <= cur_r.box_max_y) && (cur_r.box_min_y <= rd_q.max_y) &&
               (rd_q.min_z <= cur_r.box_max_z) && (cur_r.box_min_z <= rd_q.max_z);

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    rd_addr = idx_r[Iw-1:0];
    if (state_r == S_IDLE) begin
      rd_addr = (q_item.opcode == OP_READ) ? q_item.slot_index[Iw-1:0] : '0;
    end
    wr_en = 1'b0;
    wr_addr = cnt_r[Iw-1:0];
    wr_data = node_t'(0);
    wr_data.id = next_id_r;
    wr_data.kind = q_item.node_kind;
    wr_data.gen = world_gen_r + 32'd1;
    wr_data.min_x = q_item.box_min_x; wr_data.min_y = q_item.box_min_y;
    wr_data.min_z = q_item.box_min_z; wr_data.max_x = q_item.box_max_x;
    wr_data.max_y = q_item.box_max_y; wr_data.max_z = q_item.box_max_z;
    if (state_r == S_IDLE && q_valid && q_item.opcode == OP_ADD
        && cnt_r < Nw'(CAPACITY)) begin
      wr_en = 1'b1;
    end else if (state_r == S_SHIFT && found_r) begin
      wr_en = 1'b1;
      wr_addr = Iw'(idx_r - Nw'(1));
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      next_id_r <= 32'd1;
      world_gen_r <= 32'd1;
      res_v_r <= 1'b0;
      pend_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (res_v_r && !out_stall) res_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_item;
            idx_r <= '0;
            found_r <= 1'b0;
            pend_r <= 1'b0;
            case (q_item.opcode)
              OP_ADD: begin
                if (cnt_r < Nw'(CAPACITY)) begin
                  pend_item_r <= mk(ST_ADDED, wr_data, 1'b1);
                  cnt_r <= cnt_r + Nw'(1);
                  next_id_r <= next_id_r + 32'd1;
                  world_gen_r <= world_gen_r + 32'd1;
                end else begin
                  pend_item_r <= mk(ST_FULL, node_t'(0), 1'b1);
                end
                state_r <= S_OUT;
              end
              OP_READ: state_r <= S_READ;
              OP_REMOVE: state_r <= S_SHIFT;
              default: state_r <= S_SCAN;
            endcase
          end
        end
        S_READ: begin
          if ({1'b0, cur_r.slot_index} >= 7'(cnt_r))
            pend_item_r <= mk(ST_NOTFOUND, node_t'(0), 1'b1);
          else
            pend_item_r <= mk(ST_HIT, rd_q, 1'b1);
          state_r <= S_OUT;
        end
        S_SHIFT: begin
          // idx_r was the address read last cycle; rd_q holds that slot.
          if (idx_r >= cnt_r) begin
            if (found_r) begin
              cnt_r <= cnt_r - Nw'(1);
              world_gen_r <= world_gen_r + 32'd1;
            end else begin
              pend_item_r <= mk(ST_NOTFOUND, node_t'(0), 1'b1);
            end
            state_r <= S_OUT;
          end else begin
            if (!found_r && rd_q.id == cur_r.target_id) begin
              found_r <= 1'b1;
              pend_item_r <= mk(ST_REMOVED, rd_q, 1'b1);
            end
            idx_r <= idx_r + Nw'(1);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // A bubble state so rd_q holds the newly addressed slot.
          state_r <= (cur_r.opcode == OP_REMOVE) ? S_SHIFT : S_SCAN;
        end
        S_SCAN: begin
          // The latest hit is held back until the next hit or the end of the
          // table, so that the final one can carry last.
          if (idx_r >= cnt_r) begin
            if (pend_r) pend_item_r.last <= 1'b1;
            else pend_item_r <= mk(ST_NOHITS, node_t'(0), 1'b1);
            pend_r <= 1'b0;
            state_r <= S_OUT;
          end else if (!(hit && pend_r) || out_free) begin
            if (hit) begin
              if (pend_r) begin
                res_r <= pend_item_r;
                res_v_r <= 1'b1;
              end
              pend_r <= 1'b1;
              pend_item_r <= mk(ST_HIT, rd_q, 1'b0);
            end
            idx_r <= idx_r + Nw'(1);
            state_r <= S_EMIT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_r <= pend_item_r;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= Nw'(CAPACITY))
    else $error("node count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && out_stall) |=> res_v_r && $stable(res_r))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("item taken while busy");
endmodule

/* rtl/aabb_node_table_query.sv */
// Top level of the node table with add, remove, read and box overlap query.
`timescale 1ns / 1ps
// Input items arrive on in_valid / in_stall / in_item, results leave on
// out_valid / out_stall / out_item. An item is moved when valid is high and
// stall is low. A two-entry queue decouples the front from the table engine.
// Remove and query walk the table through its single read port, one stored
// node at a time, and a query gives one result per hit with last set on the
// final one (or one no-hits result). Items are handled one at a time by the
// engine. While the receiver stalls, the result register holds and the
// engine waits; the queue keeps taking items until full.
// Reset clears the node count and sets the next id and the world generation
// to one; table contents need no clearing.
module aabb_node_table_query #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  antq_pkg::in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output antq_pkg::out_item_t out_item
);
  import antq_pkg::*;

  logic q_valid, q_pop;
  in_item_t q_item;

  antq_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_valid, .q_pop, .q_item
  );

  antq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .out_valid, .out_stall, .out_item
  );
endmodule
